// ===== design/sms_pkg.sv =====
`timescale 1ns / 1ps
package sms_pkg;

  localparam int unsigned NumPointsDef = 256;
  localparam int unsigned CoordBitsDef = 20;

  // distance thresholds and score constants
  localparam int unsigned NearSq    = 160000;
  localparam int unsigned FarSq     = 1000000;
  localparam int unsigned DivOffset = 1200;
  localparam int unsigned Numer     = 256 * (NearSq + DivOffset);

  localparam int unsigned BestW = 20;
  localparam int unsigned DenW  = 21;
  localparam int unsigned NumW  = 26;
  localparam int unsigned QuoW  = 16;
  localparam int unsigned IdxSW = 10;

  typedef enum logic [1:0] {
    OP_LOAD_REF  = 2'd0,
    OP_LOAD_CAND = 2'd1,
    OP_BUILD     = 2'd2,
    OP_SCORE     = 2'd3
  } op_e;

  typedef enum logic {
    KIND_BUILT = 1'b0,
    KIND_SCORE = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RCHK,
    ST_RWIN,
    ST_CCHK,
    ST_CRD,
    ST_MX,
    ST_MY,
    ST_CMP,
    ST_REND,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

// ===== design/sms_div.sv =====
`timescale 1ns / 1ps
module sms_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sms_pkg::DenW-1:0]  den_i,
  output logic                      done_o,
  output logic [sms_pkg::QuoW-1:0]  quo_o
);
  import sms_pkg::*;

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [DenW:0]   rem_q;
  logic [DenW-1:0] den_q;
  logic [NumW-1:0] num_q;
  logic [NumW-1:0] quo_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [DenW:0]   trial;
  logic            fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q[DenW-1:0], num_q[NumW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      num_q <= NumW'(Numer);
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
      num_q <= {num_q[NumW-2:0], 1'b0};
      quo_q <= {quo_q[NumW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q[QuoW-1:0];

endmodule

// ===== design/scan_match_score_unit.sv =====
`timescale 1ns / 1ps
// load: taken in the idle state and returns no word; build: a valid reference is checked, its
// window set up and every candidate slot checked, each valid candidate read, squared in x and y
// and compared; score walks only the window slots, then runs the serial divider per reference;
// a skipped reference is only checked; the result word then holds in the output state until taken
// throughput: one command at a time; no new command is taken until the result word is taken
// reset: asynchronous active low, clears both valid bit arrays and the sequencer
module scan_match_score_unit #(
  parameter int unsigned NUM_POINTS = sms_pkg::NumPointsDef,
  parameter int unsigned COORD_BITS = sms_pkg::CoordBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  point_index_i,
  input  logic signed [19:0] coord_x_i,
  input  logic signed [19:0] coord_y_i,
  input  logic        point_valid_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [8:0]  masked_count_o,
  output logic [15:0] match_score_o
);
  import sms_pkg::*;

  localparam int unsigned AW   = $clog2(NUM_POINTS);
  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned SQW  = 2 * CB + 2;
  localparam int unsigned DW   = SQW + 1;
  localparam int unsigned SUMW = AW + QuoW;
  localparam int unsigned HALF = NUM_POINTS / 2;

  state_e state_q, state_d;

  // point and window stores
  logic [2*CB-1:0]  ref_mem  [NUM_POINTS];
  logic [2*CB-1:0]  cand_mem [NUM_POINTS];
  logic [AW+7:0]    win_mem  [NUM_POINTS];
  logic [2*CB-1:0]  ref_rd_q, cand_rd_q;
  logic [AW+7:0]    win_rd_q;
  logic [NUM_POINTS-1:0] ref_ok_q, cand_ok_q;

  logic [AW-1:0]   r_q, c_q;
  logic [8:0]      cnt_q;
  logic            score_mode_q;
  logic            found_q;
  logic signed [IdxSW-1:0] lo_q, hi_q;
  logic [BestW-1:0] best_q;
  logic [SQW-1:0]  sqx_q, sqy_q;
  logic [8:0]      masked_q;
  logic [SUMW-1:0] sum_q;
  logic            kind_q;

  logic            accept;
  logic            load_ok;
  logic [2*CB-1:0] load_xy;
  logic signed [CB:0] dx, dy, opnd;
  logic signed [SQW-1:0] prod;
  logic [DW-1:0]   sq_sum;
  logic signed [IdxSW-1:0] aligned, start_s, len_s;
  logic [AW-1:0]   win_start;
  logic [AW-1:0]   c_next;
  logic            r_last;
  logic            div_start, div_done;
  logic [QuoW-1:0] div_quo;

  assign accept  = in_valid_i && !in_stall_o;
  assign load_ok = {1'b0, point_index_i} < 9'(NUM_POINTS);
  assign load_xy = {CB'($unsigned(coord_x_i)), CB'($unsigned(coord_y_i))};

  // memory writes and registered reads
  always_ff @(posedge clk_i) begin
    if (accept && load_ok && operation_i == OP_LOAD_REF) begin
      ref_mem[point_index_i[AW-1:0]] <= load_xy;
    end
    if (accept && load_ok && operation_i == OP_LOAD_CAND) begin
      cand_mem[point_index_i[AW-1:0]] <= load_xy;
    end
    if (state_q == ST_REND && !score_mode_q && found_q) begin
      win_mem[r_q] <= {start_s[AW-1:0], len_s[7:0]};
    end
    ref_rd_q  <= ref_mem[r_q];
    cand_rd_q <= cand_mem[c_q];
    win_rd_q  <= win_mem[r_q];
  end

  // shared squarer: x term then y term
  assign dx   = $signed({cand_rd_q[2*CB-1], cand_rd_q[2*CB-1:CB]})
              - $signed({ref_rd_q[2*CB-1], ref_rd_q[2*CB-1:CB]});
  assign dy   = $signed({cand_rd_q[CB-1], cand_rd_q[CB-1:0]})
              - $signed({ref_rd_q[CB-1], ref_rd_q[CB-1:0]});
  assign opnd = (state_q == ST_MX) ? dx : dy;
  assign prod = opnd * opnd;
  assign sq_sum = DW'(sqx_q) + DW'(sqy_q);

  // wrap-aligned candidate index and window bounds
  always_comb begin
    aligned = $signed(IdxSW'(c_q));
    if (c_q >= AW'(HALF)) begin
      aligned = aligned - $signed(IdxSW'(NUM_POINTS));
    end
    start_s = lo_q - $signed(IdxSW'(2));
    if (start_s < 0) begin
      start_s = start_s + $signed(IdxSW'(NUM_POINTS));
    end
    len_s = hi_q - lo_q + $signed(IdxSW'(4));
  end

  assign win_start = win_rd_q[AW+7:8];
  assign c_next    = (c_q == AW'(NUM_POINTS - 1)) ? '0 : c_q + 1'b1;
  assign r_last    = r_q == AW'(NUM_POINTS - 1);
  assign div_start = state_q == ST_REND && score_mode_q;

  sms_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .den_i   (DenW'(best_q) + DenW'(DivOffset)),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (operation_i == OP_BUILD || operation_i == OP_SCORE)) begin
          state_d = ST_RCHK;
        end
      end
      ST_RCHK: begin
        if (ref_ok_q[r_q]) begin
          state_d = ST_RWIN;
        end else if (r_last) begin
          state_d = ST_OUT;
        end
      end
      ST_RWIN: state_d = ST_CCHK;
      ST_CCHK: begin
        if (cnt_q == '0) begin
          state_d = ST_REND;
        end else if (cand_ok_q[c_q]) begin
          state_d = ST_CRD;
        end
      end
      ST_CRD:  state_d = ST_MX;
      ST_MX:   state_d = ST_MY;
      ST_MY:   state_d = ST_CMP;
      ST_CMP:  state_d = ST_CCHK;
      ST_REND: begin
        if (score_mode_q) begin
          state_d = ST_DIV;
        end else begin
          state_d = r_last ? ST_OUT : ST_RCHK;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = r_last ? ST_OUT : ST_RCHK;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // valid bits and sequencer counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_ok_q     <= '0;
      cand_ok_q    <= '0;
      r_q          <= '0;
      c_q          <= '0;
      cnt_q        <= '0;
      score_mode_q <= 1'b0;
      found_q      <= 1'b0;
      masked_q     <= '0;
      sum_q        <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && load_ok && operation_i == OP_LOAD_REF) begin
            ref_ok_q[point_index_i[AW-1:0]] <= point_valid_i;
          end
          if (accept && load_ok && operation_i == OP_LOAD_CAND) begin
            cand_ok_q[point_index_i[AW-1:0]] <= point_valid_i;
          end
          if (accept) begin
            score_mode_q <= operation_i == OP_SCORE;
            r_q          <= '0;
            masked_q     <= '0;
            sum_q        <= '0;
          end
        end
        ST_RCHK: begin
          if (!ref_ok_q[r_q] && !r_last) begin
            r_q <= r_q + 1'b1;
          end
        end
        ST_RWIN: begin
          found_q <= 1'b0;
          if (score_mode_q) begin
            c_q   <= (win_start == AW'(NUM_POINTS - 1)) ? '0 : win_start + 1'b1;
            cnt_q <= {1'b0, win_rd_q[7:0]};
          end else begin
            c_q   <= '0;
            cnt_q <= 9'(NUM_POINTS);
          end
        end
        ST_CCHK: begin
          if (cnt_q != '0 && !cand_ok_q[c_q]) begin
            c_q   <= c_next;
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_CMP: begin
          c_q   <= c_next;
          cnt_q <= cnt_q - 1'b1;
          if (!score_mode_q && sq_sum < DW'(NearSq)) begin
            found_q <= 1'b1;
          end
        end
        ST_REND: begin
          if (!score_mode_q) begin
            if (!found_q) begin
              masked_q      <= masked_q + 1'b1;
              ref_ok_q[r_q] <= 1'b0;
            end
            if (!r_last) begin
              r_q <= r_q + 1'b1;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            sum_q <= sum_q + SUMW'(div_quo);
            if (!r_last) begin
              r_q <= r_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // distance datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RWIN) begin
      best_q <= BestW'(FarSq);
    end
    if (state_q == ST_MX) begin
      sqx_q <= SQW'(prod);
    end
    if (state_q == ST_MY) begin
      sqy_q <= SQW'(prod);
    end
    if (state_q == ST_CMP) begin
      if (score_mode_q) begin
        if (sq_sum < DW'(best_q)) begin
          best_q <= sq_sum[BestW-1:0];
        end
      end else if (sq_sum < DW'(NearSq)) begin
        if (!found_q || aligned < lo_q) begin
          lo_q <= aligned;
        end
        if (!found_q || aligned > hi_q) begin
          hi_q <= aligned;
        end
      end
    end
  end

  // result word kind
  always_ff @(posedge clk_i) begin
    if (state_q != ST_OUT && state_d == ST_OUT) begin
      kind_q <= score_mode_q ? KIND_SCORE : KIND_BUILT;
    end
  end

  // the sum holds still while the result word waits
  assign in_stall_o     = state_q != ST_IDLE;
  assign out_valid_o    = state_q == ST_OUT;
  assign result_kind_o  = kind_q;
  assign masked_count_o = kind_q ? 9'd0 : masked_q;
  assign match_score_o  = kind_q ? 16'(sum_q[SUMW-1:8]) : 16'd0;

endmodule
